// ===== src/ffc_pkg.sv =====
// Package for the float format converter: command codes and widths.
// No dependencies.
package ffc_pkg;

    localparam int OperandWidth = 32;
    localparam int ResultWidth  = 32;

    typedef enum logic [1:0] {
        CMD_F32_TO_F16  = 2'd0,
        CMD_F16_TO_F32  = 2'd1,
        CMD_F32_TO_BF16 = 2'd2,
        CMD_BF16_TO_F32 = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                    command;
        logic [OperandWidth-1:0] operand_bits;
    } ffc_in_t;

    typedef struct packed {
        logic [ResultWidth-1:0] result_bits;
    } ffc_out_t;

endpackage

// ===== src/ffc_in_if.sv =====
// Handshake channel carrying the command and the source operand.
// Depends on ffc_pkg.
interface ffc_in_if;
    logic valid;
    logic ready;
    ffc_pkg::ffc_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ffc_out_if.sv =====
// Handshake channel carrying one converted result word.
// Depends on ffc_pkg.
interface ffc_out_if;
    logic valid;
    logic ready;
    ffc_pkg::ffc_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ffc_convert.sv =====
// Combinational conversion between binary32, binary16 and bfloat16.
// Depends on ffc_pkg.
module ffc_convert (
    input  ffc_pkg::cmd_t       command,
    input  logic [31:0]         operand_bits,
    output logic [31:0]         result_bits
);
    import ffc_pkg::*;

    logic [15:0] f16_res;
    logic [31:0] f32_res;
    logic [15:0] bf16_res;

    // Narrowing from binary32 to binary16 with round to nearest even.
    always_comb
    begin
        logic [15:0] sgn;
        logic [7:0]  e;
        logic [22:0] m;
        logic [12:0] rem;
        logic [14:0] v;
        logic [23:0] mant;
        logic [4:0]  sh;
        logic [23:0] mask;
        logic [23:0] half;
        logic [23:0] rem2;
        logic [10:0] vs;
        sgn  = {operand_bits[31], 15'd0};
        e    = operand_bits[30:23];
        m    = operand_bits[22:0];
        rem  = m[12:0];
        mant = {1'b1, m};
        sh   = 5'(8'd126 - e);
        mask = (24'd1 << sh) - 24'd1;
        half = 24'd1 << (sh - 5'd1);
        rem2 = mant & mask;
        vs   = 11'(mant >> sh);
        v    = 15'd0;
        if (e == 8'hFF)
        begin
            f16_res = sgn | ((m != 23'd0) ? 16'h7E00 : 16'h7C00);
        end
        else if (e >= 8'd143)
        begin
            f16_res = sgn | 16'h7C00;
        end
        else if (e >= 8'd113)
        begin
            v = {5'(e - 8'd112), m[22:13]};
            if (rem > 13'h1000 || (rem == 13'h1000 && v[0]))
                v = v + 15'd1;
            f16_res = sgn | {1'b0, v};
        end
        else if (e < 8'd102)
        begin
            f16_res = sgn;
        end
        else
        begin
            if (rem2 > half || (rem2 == half && vs[0]))
                vs = vs + 11'd1;
            f16_res = sgn | {5'd0, vs};
        end
    end

    // Widening from binary16 to binary32, normalizing subnormals.
    always_comb
    begin
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] p;
        logic [31:0] sgn;
        sgn = {operand_bits[15], 31'd0};
        e   = operand_bits[14:10];
        m   = operand_bits[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
                p = 4'(i);
        end
        if (e == 5'd31)
        begin
            if (m == 10'd0)
                f32_res = sgn | 32'h7F800000;
            else
                f32_res = sgn | 32'h7FC00000 | {9'd0, m, 13'd0};
        end
        else if (e == 5'd0)
        begin
            if (m == 10'd0)
                f32_res = sgn;
            else
                f32_res = sgn | {1'b0, 8'({4'd0, p} + 8'd103),
                                 23'({13'd0, m} << (5'd23 - {1'b0, p}))};
        end
        else
        begin
            f32_res = sgn | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
    end

    // Narrowing from binary32 to bfloat16.
    always_comb
    begin
        logic [32:0] sum;
        sum = {1'b0, operand_bits} + 33'h7FFF + {32'd0, operand_bits[16]};
        if (operand_bits[30:0] > 31'h7F800000)
            bf16_res = operand_bits[31:16] | 16'h0040;
        else if (operand_bits[30:23] == 8'd0)
            bf16_res = {operand_bits[31], 15'd0};
        else
            bf16_res = sum[31:16];
    end

    // Result select.
    always_comb
    begin
        case (command)
            CMD_F32_TO_F16:  result_bits = {16'd0, f16_res};
            CMD_F16_TO_F32:  result_bits = f32_res;
            CMD_F32_TO_BF16: result_bits = {16'd0, bf16_res};
            CMD_BF16_TO_F32: result_bits = {operand_bits[15:0], 16'd0};
            default:         result_bits = 32'd0;
        endcase
    end
endmodule

// ===== src/float_format_converter.sv =====
// Float format converter: an accepted input word passes an input register
// and then a result register before its result is offered on the output.
// Throughput one word per cycle; the input stalls only when both registers
// are full and the output is held off. Reset (rst_n, asynchronous, active low)
// empties both registers. Depends on ffc_pkg, ffc_in_if, ffc_out_if, ffc_convert.
module float_format_converter (
    input  logic      clk,
    input  logic      rst_n,
    ffc_in_if.sink    in_ch,
    ffc_out_if.source out_ch
);
    import ffc_pkg::*;

    logic        in_valid_reg;
    ffc_in_t     in_data_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] conv_result;
    logic        out_load;
    logic        in_take;

    // Stage handshakes: each register advances when its downstream frees.
    assign out_load = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_take  = !in_valid_reg || out_load;
    assign in_ch.ready = in_take;

    ffc_convert u_convert (
        .command      (in_data_reg.command),
        .operand_bits (in_data_reg.operand_bits),
        .result_bits  (conv_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take && in_ch.valid)
            in_data_reg <= in_ch.payload;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= conv_result;
    end

    assign out_ch.valid               = out_valid_reg;
    assign out_ch.payload.result_bits = out_data_reg;

`ifndef SYNTHESIS
    // A held result must not be overwritten.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result overwritten while stalled");
    // An accepted word reaches the input register.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> in_valid_reg)
        else $error("accepted word lost");
    // A full input stage with a free output always advances.
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pipeline stalled with free output");
`endif
endmodule

// ===== verif/ffc_checker.sv =====
// Checker for the float format converter: watches both channels, predicts
// each converted word and compares it with the block's output.
// Depends on ffc_pkg, ffc_in_if and ffc_out_if.
module ffc_checker
    import ffc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ffc_in_if      in_ch,
    ffc_out_if     out_ch,
    output int     fail_count,
    output int     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] expected_words[$];

    // Narrow binary32 to binary16 with round-to-nearest-even.
    function automatic logic [31:0] narrow_to_half(input logic [31:0] x);
        logic [31:0] sign;
        logic [31:0] e;
        logic [31:0] m;
        logic [31:0] v;
        logic [31:0] rem;
        logic [31:0] mant;
        logic [31:0] sh;
        logic [31:0] half;
        sign = (x >> 16) & 32'h8000;
        e = (x >> 23) & 32'hFF;
        m = x & 32'h7FFFFF;
        if (e == 32'hFF)
        begin
            return sign | ((m != 0) ? 32'h7E00 : 32'h7C00);
        end
        if (e >= 143)
        begin
            return sign | 32'h7C00;
        end
        if (e >= 113)
        begin
            rem = m & 32'h1FFF;
            v = ((e - 112) << 10) | (m >> 13);
            if (rem > 32'h1000 || (rem == 32'h1000 && v[0]))
            begin
                v++;
            end
            return sign | v;
        end
        if (e < 102)
        begin
            return sign;
        end
        mant = m | 32'h800000;
        sh = 126 - e;
        half = 32'd1 << (sh - 1);
        rem = mant & ((32'd1 << sh) - 1);
        v = mant >> sh;
        if (rem > half || (rem == half && v[0]))
        begin
            v++;
        end
        return sign | v;
    endfunction

    // Widen binary16 to binary32 exactly.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sign;
        logic [31:0] e;
        logic [31:0] m;
        int p;
        sign = {h[15], 31'd0};
        e = h[14:10];
        m = h[9:0];
        if (e == 31)
        begin
            return (m == 0) ? (sign | 32'h7F800000)
                            : (sign | 32'h7FC00000 | (m << 13));
        end
        if (e == 0)
        begin
            if (m == 0)
            begin
                return sign;
            end
            p = 9;
            while (m[p] == 1'b0)
            begin
                p--;
            end
            return sign | ((p + 103) << 23) | ((m << (23 - p)) & 32'h7FFFFF);
        end
        return sign | ((e + 112) << 23) | (m << 13);
    endfunction

    // Narrow binary32 to bfloat16; subnormals flush, NaNs are quieted.
    function automatic logic [31:0] narrow_to_brain(input logic [31:0] x);
        logic [32:0] sum;
        if ((x & 32'h7FFFFFFF) > 32'h7F800000)
        begin
            return ((x >> 16) | 32'h0040) & 32'hFFFF;
        end
        if ((x & 32'h7F800000) == 0)
        begin
            return (x >> 16) & 32'h8000;
        end
        sum = {1'b0, x} + 33'h7FFF + x[16];
        return {16'd0, sum[31:16]};
    endfunction

    function automatic logic [31:0] convert_word(input ffc_in_t w);
        case (w.command)
            CMD_F32_TO_F16:  return narrow_to_half(w.operand_bits);
            CMD_F16_TO_F32:  return widen_half(w.operand_bits[15:0]);
            CMD_F32_TO_BF16: return narrow_to_brain(w.operand_bits);
            default:         return {w.operand_bits[15:0], 16'd0};
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    assign pending_count = expected_words.size();

    // Predict on input accept, compare on output accept.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_words.push_back(convert_word(in_ch.payload));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word %h",
                                              out_ch.payload.result_bits));
                end
                else if (out_ch.payload.result_bits != expected_words[0])
                begin
                    report_mismatch($sformatf("result_bits %h, expected %h",
                                              out_ch.payload.result_bits,
                                              expected_words.pop_front()));
                end
                else
                begin
                    void'(expected_words.pop_front());
                end
            end
        end
    end
endmodule

// ===== verif/float_format_converter_tb.sv =====
// Testbench top for the float format converter: drives commands and
// operands, stalls the output, and gives the verdict from ffc_checker.
// Depends on ffc_pkg, ffc_in_if, ffc_out_if, the block and ffc_checker.
module float_format_converter_tb;
    import ffc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomWords = 600;
    localparam int CycleLimit  = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    bit   long_hold;

    ffc_in_if  in_ch ();
    ffc_out_if out_ch ();

    float_format_converter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ffc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Give up if the run stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Send one word, then wait the given gap.
    task automatic send_word(input cmd_t cmd, input logic [31:0] bits, input int gap);
        in_ch.valid <= 1'b1;
        in_ch.payload <= '{command: cmd, operand_bits: bits};
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random operand weighted toward interesting exponents per command.
    function automatic logic [31:0] pick_operand(input cmd_t cmd);
        logic [31:0] x;
        x = $urandom;
        if ($urandom_range(0, 2) != 0)
        begin
            if (cmd == CMD_F32_TO_F16 || cmd == CMD_F32_TO_BF16)
            begin
                case ($urandom_range(0, 3))
                    0: x[30:23] = 8'($urandom_range(98, 146));
                    1: x[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                    2: x[12:0] = ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0FFF;
                    default: x[15:0] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
                endcase
            end
            else
            begin
                x[14:10] = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'd31;
            end
        end
        return x;
    endfunction

    // Output side: random stalls per word, with one long hold-off.
    initial
    begin
        int wait_cycles;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (60) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (wait_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [31:0] directed[] = '{32'h00000000, 32'h80000000, 32'hFFFFFFFF,
            32'h7F800000, 32'hFF800000, 32'h7F800001, 32'h477FF000,
            32'h477FEFFF, 32'h38800000, 32'h33000000, 32'h33000001,
            32'h00000001, 32'h3F801000, 32'h3F803000, 32'h3F808000,
            32'h3F818000, 32'hFFFF7C00, 32'h00000200, 32'h00007E01,
            32'h0000FC00, 32'h7F7FFFFF};
        cmd_t cmd;
        int gap;
        long_hold = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command on every extreme pattern.
        foreach (directed[i])
        begin
            for (int c = 0; c < 4; c++)
            begin
                send_word(cmd_t'(c), directed[i], 0);
            end
        end

        // Pause until the pipeline drains.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end

        // Back-to-back words against a long output hold-off.
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            cmd = cmd_t'($urandom_range(0, 3));
            send_word(cmd, pick_operand(cmd), 0);
        end

        for (int i = 0; i < RandomWords; i++)
        begin
            cmd = cmd_t'($urandom_range(0, 3));
            gap = ((i / 50) % 2 == 0) ? 0 : $urandom_range(0, 19);
            send_word(cmd, pick_operand(cmd), gap);
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);

        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
